@@ rtl/kcl_pkg.sv @@
// Package for the keypad code lock: key layout, codes and result type.
package kcl_pkg;

  localparam int unsigned CodeLen   = 4;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CodeW     = CodeLen * CharW;
  localparam int unsigned KeyW      = 4;
  localparam int unsigned CountW    = $clog2(CodeLen);
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CodeW-1:0] ResetCode = 32'h3131_3131;
  localparam logic [CharW-1:0] StarChar  = 8'h2A;
  localparam logic [CharW-1:0] NullChar  = 8'h00;

  localparam logic [CfgIdxW-1:0] CfgIdCode   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPassCode = 1'b1;

  typedef enum logic [1:0] {
    VerdictNone    = 2'd0,
    VerdictGranted = 2'd1,
    VerdictDenied  = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [CharW-1:0] echo_char;
    logic             in_pass_phase;
    verdict_e         verdict;
    logic             unlocked;
  } result_t;

  function automatic logic [CharW-1:0] key_char(input logic [KeyW-1:0] key);
    logic [CharW-1:0] ch;
    case (key)
      4'd0:    ch = "7";
      4'd1:    ch = "8";
      4'd2:    ch = "9";
      4'd3:    ch = "/";
      4'd4:    ch = "4";
      4'd5:    ch = "5";
      4'd6:    ch = "6";
      4'd7:    ch = "*";
      4'd8:    ch = "1";
      4'd9:    ch = "2";
      4'd10:   ch = "3";
      4'd11:   ch = "-";
      4'd12:   ch = "C";
      4'd13:   ch = "0";
      4'd14:   ch = "=";
      4'd15:   ch = "+";
      default: ch = NullChar;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/keypad_code_lock.sv @@
// Keypad code lock: ID and password entry, code compare and result buffering.
// Results are registered in the head register, or in the skid entry while the head waits.
// Throughput: one key press per cycle; a two-entry output buffer keeps the input
// open while one result waits, and stall rises only when both entries are full.
// Reset: ID phase, character count zero, locked, both codes 0x31313131 ("1111"),
// output buffer empty; the character buffers are written before they are read.
module keypad_code_lock (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kcl_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [kcl_pkg::CodeW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kcl_pkg::KeyW-1:0]          key_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kcl_pkg::CharW-1:0]         echo_char_o,
  output logic                              in_pass_phase_o,
  output logic [1:0]                        verdict_o,
  output logic                              unlocked_o
);

  logic [kcl_pkg::CodeW-1:0]  id_code_q, pass_code_q;
  logic                       pass_phase_q, pass_phase_d;
  logic [kcl_pkg::CountW-1:0] count_q, count_d;
  logic                       granted_q, granted_d;
  logic [kcl_pkg::CharW-1:0]  id_buf_q   [kcl_pkg::CodeLen];
  logic [kcl_pkg::CharW-1:0]  pass_buf_q [kcl_pkg::CodeLen];

  kcl_pkg::result_t out_q, out_d, skid_q, skid_d, res;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic             push, pop, last;
  logic [kcl_pkg::CharW-1:0] ch;
  logic [kcl_pkg::CodeW-1:0] id_word, pass_word;

  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_q && !out_stall_i;
  assign ch   = kcl_pkg::key_char(key_index_i);
  assign last = (count_q == kcl_pkg::CountW'(kcl_pkg::CodeLen - 1));

  assign id_word   = {id_buf_q[3], id_buf_q[2], id_buf_q[1], id_buf_q[0]};
  assign pass_word = {ch, pass_buf_q[2], pass_buf_q[1], pass_buf_q[0]};

  // Key press handling and result.
  always_comb begin
    pass_phase_d = pass_phase_q;
    count_d      = count_q;
    granted_d    = granted_q;
    res          = '{echo_char: kcl_pkg::NullChar, in_pass_phase: 1'b0,
                     verdict: kcl_pkg::VerdictNone, unlocked: 1'b1};
    if (!granted_q) begin
      count_d = count_q + 1'b1;
      if (!pass_phase_q) begin
        res.echo_char = ch;
        if (last) begin
          pass_phase_d = 1'b1;
        end
      end else begin
        res.echo_char = kcl_pkg::StarChar;
        if (last) begin
          if (id_word == id_code_q && pass_word == pass_code_q) begin
            granted_d   = 1'b1;
            res.verdict = kcl_pkg::VerdictGranted;
          end else begin
            pass_phase_d = 1'b0;
            res.verdict  = kcl_pkg::VerdictDenied;
          end
        end
      end
      res.in_pass_phase = pass_phase_d && !granted_d;
      res.unlocked      = granted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_code_q    <= kcl_pkg::ResetCode;
      pass_code_q  <= kcl_pkg::ResetCode;
      pass_phase_q <= 1'b0;
      count_q      <= '0;
      granted_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          kcl_pkg::CfgIdCode:   id_code_q   <= cfg_data_i;
          kcl_pkg::CfgPassCode: pass_code_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push) begin
        pass_phase_q <= pass_phase_d;
        count_q      <= count_d;
        granted_q    <= granted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !granted_q) begin
      if (!pass_phase_q) begin
        id_buf_q[count_q] <= ch;
      end else begin
        pass_buf_q[count_q] <= ch;
      end
    end
  end

  // Two-entry output buffer: head register plus skid entry.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      out_valid_d  = skid_valid_q || push;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = skid_valid_q && push;
      if (skid_valid_q && push) begin
        skid_d = res;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign echo_char_o     = out_q.echo_char;
  assign in_pass_phase_o = out_q.in_pass_phase;
  assign verdict_o       = out_q.verdict;
  assign unlocked_o      = out_q.unlocked;

endmodule
